>>> rtl/core/dpbs_pkg.sv
// shared types and constants of the data pdu burst segmenter
`timescale 1ns / 1ps

package dpbs_pkg;

  localparam int LEN_W = 24;
  localparam int OFS_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 168;
  localparam int M_TUSER_W = 3;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [LEN_W-1:0] MAX_SEGMENT_RESET = 24'd8192;
  localparam logic [LEN_W-1:0] FIRST_BURST_RESET = 24'd65536;
  localparam logic [LEN_W-1:0] MAX_BURST_RESET = 24'd262144;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BURST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BURST = 2'd2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_IMMEDIATE   = 2'd0,
    KIND_UNSOLICITED = 2'd1,
    KIND_NORMAL      = 2'd2
  } pdu_kind_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_segment_length;
    logic [LEN_W-1:0] first_burst_length;
    logic [LEN_W-1:0] max_burst_length;
  } cfg_t;

  typedef struct packed {
    cmd_t             command;
    logic [OFS_W-1:0] transfer_length;
    logic             has_immediate;
    logic [LEN_W-1:0] immediate_length;
    logic [LEN_W-1:0] unsolicited_length;
  } entry_t;

  typedef struct packed {
    logic             pdu_valid;
    logic [OFS_W-1:0] pdu_offset;
    logic [LEN_W-1:0] pdu_length;
    pdu_kind_t        pdu_kind;
    logic [LEN_W-1:0] sequence_number;
    logic             first_in_sequence;
    logic             last_in_sequence;
    logic [OFS_W-1:0] sequence_start_offset;
    logic [LEN_W-1:0] sequence_bytes;
    logic [LEN_W-1:0] sequence_pdus;
    logic             transfer_done;
  } result_t;

endpackage

>>> rtl/core/dpbs_front.sv
// front end: configuration registers, input acceptance and command classification
`timescale 1ns / 1ps

module dpbs_front
  import dpbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [LEN_W-1:0]         cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [S_TDATA_W-1:0]     s_tdata,
  input  logic                     s_tuser,
  input  logic                     queue_full,
  output logic                     push,
  output entry_t                   push_entry,
  output cfg_t                     cfg
);

  cfg_t             cfg_regs;
  logic [OFS_W-1:0] length_in;
  logic [LEN_W-1:0] first_burst_clamped;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.max_segment_length <= MAX_SEGMENT_RESET;
      cfg_regs.first_burst_length <= FIRST_BURST_RESET;
      cfg_regs.max_burst_length   <= MAX_BURST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_SEGMENT: cfg_regs.max_segment_length <= cfg_data;
        REG_FIRST_BURST: cfg_regs.first_burst_length <= cfg_data;
        REG_MAX_BURST:   cfg_regs.max_burst_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready  = !queue_full;
  assign push      = s_tvalid && s_tready;
  assign length_in = s_tdata[OFS_W-1:0];

  // unsolicited budget is min(transfer length, first burst)
  always_comb begin
    if (length_in < {{(OFS_W-LEN_W){1'b0}}, cfg_regs.first_burst_length}) begin
      first_burst_clamped = length_in[LEN_W-1:0];
    end else begin
      first_burst_clamped = cfg_regs.first_burst_length;
    end
  end

  always_comb begin
    push_entry.command            = cmd_t'(s_tuser);
    push_entry.transfer_length    = length_in;
    push_entry.has_immediate      = s_tdata[OFS_W];
    push_entry.immediate_length   = s_tdata[OFS_W+2+LEN_W-1:OFS_W+2];
    push_entry.unsolicited_length = s_tdata[OFS_W+1] ? first_burst_clamped : '0;
  end

endmodule

>>> rtl/core/dpbs_fifo.sv
// command queue between front end and segmentation engine
`timescale 1ns / 1ps

module dpbs_fifo
  import dpbs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/dpbs_engine.sv
// segmentation engine: transfer state, pdu descriptor generation and output register
`timescale 1ns / 1ps

module dpbs_engine
  import dpbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    queue_empty,
  input  entry_t  entry,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic [OFS_W-1:0] remaining, remaining_next;
  logic [OFS_W-1:0] current_offset, current_offset_next;
  logic [LEN_W-1:0] burst_bytes, burst_bytes_next;
  logic [LEN_W-1:0] unsolicited_left, unsolicited_left_next;
  logic             immediate_pending, immediate_pending_next;
  logic [LEN_W-1:0] immediate_bytes, immediate_bytes_next;
  logic [LEN_W-1:0] burst_index, burst_index_next;
  logic [LEN_W-1:0] pdus_in_burst, pdus_in_burst_next;
  logic [OFS_W-1:0] burst_start, burst_start_next;
  result_t          result;

  assign pop = !queue_empty && (!out_valid || out_ready);

  always_comb begin
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] room;
    logic [LEN_W:0]   burst_sum;
    logic [LEN_W-1:0] pdus_inc;
    logic [OFS_W-1:0] start_ofs;
    logic             first;
    logic             close;
    logic             done;
    pdu_kind_t        kind;

    remaining_next         = remaining;
    current_offset_next    = current_offset;
    burst_bytes_next       = burst_bytes;
    unsolicited_left_next  = unsolicited_left;
    immediate_pending_next = immediate_pending;
    immediate_bytes_next   = immediate_bytes;
    burst_index_next       = burst_index;
    pdus_in_burst_next     = pdus_in_burst;
    burst_start_next       = burst_start;
    result                 = '0;

    len       = '0;
    close     = 1'b0;
    kind      = KIND_NORMAL;
    first     = (pdus_in_burst == '0);
    pdus_inc  = pdus_in_burst + 1'b1;
    start_ofs = first ? current_offset : burst_start;
    room      = (cfg.max_burst_length > burst_bytes) ?
                cfg.max_burst_length - burst_bytes : '0;
    burst_sum = {1'b0, burst_bytes} + {1'b0, cfg.max_segment_length};
    done      = 1'b0;

    if (entry.command == CMD_START) begin
      remaining_next         = entry.transfer_length;
      current_offset_next    = '0;
      burst_bytes_next       = '0;
      burst_index_next       = '0;
      pdus_in_burst_next     = '0;
      burst_start_next       = '0;
      immediate_pending_next = entry.has_immediate;
      immediate_bytes_next   = entry.immediate_length;
      unsolicited_left_next  = entry.unsolicited_length;
    end else if (remaining != '0) begin
      if (immediate_pending) begin
        kind  = KIND_IMMEDIATE;
        close = 1'b1;
        if (remaining < {{(OFS_W-LEN_W){1'b0}}, immediate_bytes}) begin
          len = remaining[LEN_W-1:0];
        end else begin
          len = immediate_bytes;
        end
        immediate_pending_next = 1'b0;
        unsolicited_left_next  = (unsolicited_left > len) ? unsolicited_left - len : '0;
      end else if (unsolicited_left != '0) begin
        kind = KIND_UNSOLICITED;
        if (cfg.max_segment_length >= unsolicited_left) begin
          len   = unsolicited_left;
          close = 1'b1;
        end else begin
          len = cfg.max_segment_length;
        end
        if ({{(OFS_W-LEN_W){1'b0}}, len} > remaining) begin
          len   = remaining[LEN_W-1:0];
          close = 1'b1;
        end
        unsolicited_left_next = unsolicited_left - len;
      end else begin
        kind = KIND_NORMAL;
        if (burst_sum >= {1'b0, cfg.max_burst_length}) begin
          len   = room;
          close = 1'b1;
        end else begin
          len = cfg.max_segment_length;
        end
        if (remaining <= {{(OFS_W-LEN_W){1'b0}}, len}) begin
          len   = remaining[LEN_W-1:0];
          close = 1'b1;
        end
      end

      done  = ({{(OFS_W-LEN_W){1'b0}}, len} >= remaining);
      close = close || done;

      result.pdu_valid             = 1'b1;
      result.pdu_offset            = current_offset;
      result.pdu_length            = len;
      result.pdu_kind              = kind;
      result.sequence_number       = burst_index;
      result.first_in_sequence     = first;
      result.last_in_sequence      = close;
      result.sequence_start_offset = start_ofs;
      result.sequence_bytes        = close ? burst_bytes + len : '0;
      result.sequence_pdus         = close ? pdus_inc : '0;
      result.transfer_done         = done;

      remaining_next      = remaining - {{(OFS_W-LEN_W){1'b0}}, len};
      current_offset_next = current_offset + {{(OFS_W-LEN_W){1'b0}}, len};
      burst_start_next    = start_ofs;
      if (close) begin
        burst_bytes_next   = '0;
        pdus_in_burst_next = '0;
        burst_index_next   = burst_index + 1'b1;
      end else begin
        burst_bytes_next   = burst_bytes + len;
        pdus_in_burst_next = pdus_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining         <= '0;
      current_offset    <= '0;
      burst_bytes       <= '0;
      unsolicited_left  <= '0;
      immediate_pending <= 1'b0;
      immediate_bytes   <= '0;
      burst_index       <= '0;
      pdus_in_burst     <= '0;
      burst_start       <= '0;
    end else if (pop) begin
      remaining         <= remaining_next;
      current_offset    <= current_offset_next;
      burst_bytes       <= burst_bytes_next;
      unsolicited_left  <= unsolicited_left_next;
      immediate_pending <= immediate_pending_next;
      immediate_bytes   <= immediate_bytes_next;
      burst_index       <= burst_index_next;
      pdus_in_burst     <= pdus_in_burst_next;
      burst_start       <= burst_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

endmodule

>>> rtl/core/data_pdu_burst_segmenter.sv
// top level of the data pdu burst segmenter
// an accepted transaction is written into the command queue; the engine pops it and registers its result onto m_*
// throughput: one transaction per cycle while m_tready does not stall the output, set by the engine state update
// the command queue lets input and output stall independently
// reset: synchronous, clears transfer state and queue, loads register defaults; no clearing pass
`timescale 1ns / 1ps

module data_pdu_burst_segmenter
  import dpbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // transfer_length, has_immediate, has_unsolicited, immediate_length, zero fill
  input  logic [S_TDATA_W-1:0] s_tdata,
  // command
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // pdu_offset, pdu_length, sequence_number, first_in_sequence, last_in_sequence,
  // sequence_start_offset, sequence_bytes, sequence_pdus, zero fill
  output logic [M_TDATA_W-1:0] m_tdata,
  // pdu_valid, pdu_kind
  output logic [M_TUSER_W-1:0] m_tuser,
  // transfer_done
  output logic                 m_tlast
);

  cfg_t    cfg;
  entry_t  push_entry;
  entry_t  pop_entry;
  logic    push;
  logic    pop;
  logic    queue_full;
  logic    queue_empty;
  result_t out_data;

  dpbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry),
    .cfg        (cfg)
  );

  dpbs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (queue_empty)
  );

  dpbs_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .entry       (pop_entry),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (out_data)
  );

  assign m_tdata = {6'd0,
                    out_data.sequence_pdus,
                    out_data.sequence_bytes,
                    out_data.sequence_start_offset,
                    out_data.last_in_sequence,
                    out_data.first_in_sequence,
                    out_data.sequence_number,
                    out_data.pdu_length,
                    out_data.pdu_offset};
  assign m_tuser = {out_data.pdu_kind, out_data.pdu_valid};
  assign m_tlast = out_data.transfer_done;

endmodule

>>> bench/tb_data_pdu_burst_segmenter.sv
// self-checking testbench of the data pdu burst segmenter
`timescale 1ns / 1ps

module tb_data_pdu_burst_segmenter
  import dpbs_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET = 1200;

  typedef struct {
    logic                 is_cfg;
    cmd_t                 cmd;
    logic [OFS_W-1:0]     xlen;
    logic                 imm;
    logic                 unsol;
    logic [LEN_W-1:0]     ilen;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [LEN_W-1:0]     reg_val;
    logic                 typed;
    result_t              want;
  } row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 m_tlast;

  // segmenter state mirror
  logic [OFS_W-1:0] xfer_total, cur_offset, burst_origin;
  logic [LEN_W-1:0] burst_fill, unsol_left, imm_bytes, burst_num, burst_pdus;
  logic             imm_pending;
  logic [LEN_W-1:0] seg_limit, first_burst, burst_limit;

  result_t expected_pdus[$];
  row_t    directed_rows[$];

  int mismatches = 0;
  int checked = 0;
  int work_items = 0;
  int n_starts = 0;
  int n_pdus = 0;
  int n_done = 0;
  int n_writes = 0;
  int idle_run = 0;
  int calm_count = 0;
  int stall_left = 0;
  logic calm = 1'b0;

  data_pdu_burst_segmenter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t segment_step(input cmd_t cmd, input logic [OFS_W-1:0] xlen,
                                           input logic imm, input logic unsol,
                                           input logic [LEN_W-1:0] ilen);
    result_t          r;
    logic [OFS_W-1:0] rem, plen;
    logic [LEN_W-1:0] room;
    logic [LEN_W:0]   fill_sum;
    logic             first, close, done;
    pdu_kind_t        kind;
    r = '0;
    if (cmd == CMD_START) begin
      xfer_total = xlen;
      cur_offset = '0;
      burst_fill = '0;
      burst_num = '0;
      burst_pdus = '0;
      burst_origin = '0;
      imm_pending = imm;
      imm_bytes = ilen;
      if (unsol) unsol_left = (xlen < first_burst) ? xlen[LEN_W-1:0] : first_burst;
      else unsol_left = '0;
      return r;
    end
    if (cur_offset >= xfer_total) return r;
    rem = xfer_total - cur_offset;
    first = (burst_pdus == 0);
    if (first) burst_origin = cur_offset;
    burst_pdus = burst_pdus + 1'b1;
    if (imm_pending) begin
      imm_pending = 1'b0;
      kind = KIND_IMMEDIATE;
      plen = (imm_bytes < rem) ? imm_bytes : rem;
      unsol_left = (unsol_left > plen) ? unsol_left - plen[LEN_W-1:0] : '0;
      close = 1'b1;
    end else if (unsol_left != 0) begin
      kind = KIND_UNSOLICITED;
      if (seg_limit >= unsol_left) begin
        plen = OFS_W'(unsol_left);
        close = 1'b1;
      end else begin
        plen = OFS_W'(seg_limit);
        close = 1'b0;
      end
      if (plen > rem) begin
        plen = rem;
        close = 1'b1;
      end
      unsol_left = unsol_left - ((plen < unsol_left) ? plen[LEN_W-1:0] : unsol_left);
    end else begin
      kind = KIND_NORMAL;
      room = (burst_limit > burst_fill) ? burst_limit - burst_fill : '0;
      fill_sum = {1'b0, burst_fill} + {1'b0, seg_limit};
      if (fill_sum >= {1'b0, burst_limit}) begin
        plen = OFS_W'(room);
        close = 1'b1;
      end else begin
        plen = OFS_W'(seg_limit);
        close = 1'b0;
      end
      if (rem <= plen) begin
        plen = rem;
        close = 1'b1;
      end
    end
    done = (plen >= rem);
    if (done) close = 1'b1;
    r.pdu_valid = 1'b1;
    r.pdu_offset = cur_offset;
    r.pdu_length = plen[LEN_W-1:0];
    r.pdu_kind = kind;
    r.sequence_number = burst_num;
    r.first_in_sequence = first;
    r.last_in_sequence = close;
    r.sequence_start_offset = burst_origin;
    r.sequence_bytes = close ? burst_fill + plen[LEN_W-1:0] : '0;
    r.sequence_pdus = close ? burst_pdus : '0;
    r.transfer_done = done;
    cur_offset = cur_offset + plen;
    if (close) begin
      burst_fill = '0;
      burst_pdus = '0;
      burst_num = burst_num + 1'b1;
    end else begin
      burst_fill = burst_fill + plen[LEN_W-1:0];
    end
    return r;
  endfunction

  function automatic result_t pdu(input logic [OFS_W-1:0] ofs, input logic [LEN_W-1:0] plen,
                                  input pdu_kind_t kind, input logic [LEN_W-1:0] seq,
                                  input logic first, input logic last,
                                  input logic [OFS_W-1:0] sso, input logic [LEN_W-1:0] sb,
                                  input logic [LEN_W-1:0] sp, input logic done);
    result_t r;
    r.pdu_valid = 1'b1;
    r.pdu_offset = ofs;
    r.pdu_length = plen;
    r.pdu_kind = kind;
    r.sequence_number = seq;
    r.first_in_sequence = first;
    r.last_in_sequence = last;
    r.sequence_start_offset = sso;
    r.sequence_bytes = sb;
    r.sequence_pdus = sp;
    r.transfer_done = done;
    return r;
  endfunction

  function automatic row_t item_row(input cmd_t cmd, input logic [OFS_W-1:0] xlen,
                                    input logic imm, input logic unsol,
                                    input logic [LEN_W-1:0] ilen);
    row_t r;
    r = '{cmd: CMD_START, default: '0};
    r.cmd = cmd;
    r.xlen = xlen;
    r.imm = imm;
    r.unsol = unsol;
    r.ilen = ilen;
    return r;
  endfunction

  function automatic row_t typed_row(input row_t r, input result_t want);
    row_t t;
    t = r;
    t.typed = 1'b1;
    t.want = want;
    return t;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    row_t r;
    r = '{cmd: CMD_START, default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic int pick_gap_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [LEN_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'd512;
    if (r == 1) return 24'hFFFFFF;
    if (r == 2) return LEN_W'($urandom_range(512, 24'hFFFFFF));
    case (idx)
      REG_MAX_SEGMENT: return LEN_W'($urandom_range(512, 4096));
      REG_FIRST_BURST: return LEN_W'($urandom_range(512, 32768));
      default:         return LEN_W'($urandom_range(512, 65536));
    endcase
  endfunction

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic issue(input cmd_t cmd, input logic [OFS_W-1:0] xlen, input logic imm,
                       input logic unsol, input logic [LEN_W-1:0] ilen, input logic typed,
                       input result_t want, output result_t pred);
    int   gap;
    logic ready_seen;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : pick_gap_len();
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {6'b0, ilen, unsol, imm, xlen};
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
    pred = segment_step(cmd, xlen, imm, unsol, ilen);
    expected_pdus.push_back(typed ? want : pred);
    if (cmd == CMD_START) n_starts++;
    if (pred.pdu_valid) n_pdus++;
    if (pred.transfer_done) n_done++;
    if (cmd == CMD_START || pred.pdu_valid) work_items++;
  endtask

  task automatic drain_pdus();
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_pdus.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // leaves cfg_valid high so that writes can follow back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    logic ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    case (idx)
      REG_MAX_SEGMENT: seg_limit = val;
      REG_FIRST_BURST: first_burst = val;
      REG_MAX_BURST:   burst_limit = val;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic reprogram();
    int k;
    k = $urandom_range(0, 3);
    if (k == 3) begin
      write_reg(REG_MAX_SEGMENT, pick_reg_value(REG_MAX_SEGMENT));
      write_reg(REG_FIRST_BURST, pick_reg_value(REG_FIRST_BURST));
      write_reg(REG_MAX_BURST, pick_reg_value(REG_MAX_BURST));
    end else begin
      write_reg(CFG_IDX_W'(k), pick_reg_value(CFG_IDX_W'(k)));
    end
  endtask

  task automatic run_transfer();
    int               scen, n;
    result_t          pred;
    logic [OFS_W-1:0] xlen;
    logic [LEN_W-1:0] ilen;
    scen = $urandom_range(0, 19);
    if (scen < 14 || scen >= 18) begin
      if ($urandom_range(0, 9) == 0) xlen = $urandom_range(0, 600);
      else if ($urandom_range(0, 9) == 0) xlen = $urandom_range(1, 60000);
      else xlen = $urandom_range(1, 12000);
      ilen = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 6000));
      issue(CMD_START, xlen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ilen, 1'b0,
            '0, pred);
      n = 0;
      do begin
        // registers rewritten in the middle of a transfer
        if (scen >= 18 && n == 2) begin
          drain_pdus();
          reprogram();
        end
        issue(CMD_NEXT, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              LEN_W'($urandom), 1'b0, '0, pred);
        n++;
      end while (pred.pdu_valid && !pred.transfer_done && n < 600);
      if ($urandom_range(0, 4) == 0)
        issue(CMD_NEXT, $urandom, 1'b0, 1'b0, '0, 1'b0, '0, pred);
    end else if (scen < 17) begin
      issue(CMD_START, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            LEN_W'($urandom), 1'b0, '0, pred);
      repeat ($urandom_range(0, 6))
        issue(CMD_NEXT, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              LEN_W'($urandom), 1'b0, '0, pred);
    end else begin
      repeat ($urandom_range(1, 6))
        issue(cmd_t'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), LEN_W'($urandom), 1'b0, '0, pred);
    end
  endtask

  initial begin
    result_t pred;
    row_t    row;
    xfer_total = '0;
    cur_offset = '0;
    burst_origin = '0;
    burst_fill = '0;
    unsol_left = '0;
    imm_bytes = '0;
    burst_num = '0;
    burst_pdus = '0;
    imm_pending = 1'b0;
    seg_limit = MAX_SEGMENT_RESET;
    first_burst = FIRST_BURST_RESET;
    burst_limit = MAX_BURST_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed_rows.push_back(typed_row(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0), '0));
    directed_rows.push_back(typed_row(item_row(CMD_START, '0, 1'b0, 1'b0, '0), '0));
    directed_rows.push_back(typed_row(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0), '0));
    directed_rows.push_back(typed_row(item_row(CMD_START, 32'd20000, 1'b1, 1'b1, 24'd1000), '0));
    directed_rows.push_back(typed_row(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0),
      pdu(32'd0, 24'd1000, KIND_IMMEDIATE, 24'd0, 1'b1, 1'b1, 32'd0, 24'd1000, 24'd1, 1'b0)));
    repeat (3) directed_rows.push_back(item_row(CMD_NEXT, '1, 1'b1, 1'b1, '1));
    directed_rows.push_back(typed_row(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0), '0));
    // immediate data longer than the whole transfer
    directed_rows.push_back(typed_row(item_row(CMD_START, 32'd100, 1'b1, 1'b1, 24'hFFFFFF), '0));
    directed_rows.push_back(typed_row(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0),
      pdu(32'd0, 24'd100, KIND_IMMEDIATE, 24'd0, 1'b1, 1'b1, 32'd0, 24'd100, 24'd1, 1'b1)));
    directed_rows.push_back(typed_row(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0), '0));
    directed_rows.push_back(typed_row(item_row(CMD_START, 32'hFFFFFFFF, 1'b0, 1'b0, '0), '0));
    directed_rows.push_back(typed_row(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0),
      pdu(32'd0, 24'd8192, KIND_NORMAL, 24'd0, 1'b1, 1'b0, 32'd0, 24'd0, 24'd0, 1'b0)));
    repeat (2) directed_rows.push_back(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0));
    // burst limit lowered below what the open burst already holds
    directed_rows.push_back(cfg_row(REG_MAX_BURST, 24'd512));
    directed_rows.push_back(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0));
    // zero segment limit gives empty pdus
    directed_rows.push_back(cfg_row(REG_MAX_SEGMENT, 24'd0));
    repeat (2) directed_rows.push_back(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0));
    directed_rows.push_back(cfg_row(REG_MAX_SEGMENT, 24'hFFFFFF));
    directed_rows.push_back(cfg_row(REG_MAX_BURST, 24'hFFFFFF));
    directed_rows.push_back(cfg_row(REG_FIRST_BURST, 24'hFFFFFF));
    directed_rows.push_back(item_row(CMD_START, 32'h01000000, 1'b1, 1'b1, 24'd0));
    repeat (3) directed_rows.push_back(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0));
    directed_rows.push_back(cfg_row(REG_MAX_SEGMENT, 24'd512));
    directed_rows.push_back(cfg_row(REG_FIRST_BURST, 24'd512));
    directed_rows.push_back(cfg_row(REG_MAX_BURST, 24'd512));
    directed_rows.push_back(item_row(CMD_START, 32'd1500, 1'b1, 1'b1, 24'd300));
    repeat (5) directed_rows.push_back(item_row(CMD_NEXT, '0, 1'b0, 1'b0, '0));

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.is_cfg) begin
        drain_pdus();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        issue(row.cmd, row.xlen, row.imm, row.unsol, row.ilen, row.typed, row.want, pred);
      end
    end

    // sender holds off until every descriptor is back
    drain_pdus();

    while (work_items < ITEM_TARGET) begin
      drain_pdus();
      reprogram();
      repeat ($urandom_range(3, 8)) run_transfer();
    end

    drain_pdus();
    repeat (10) @(posedge clk);
    $display("run covered %0d transfers started, %0d pdu descriptors, %0d finished transfers",
             n_starts, n_pdus, n_done);
    $display("%0d results checked across %0d register writes, %0d mismatches",
             checked, n_writes, mismatches);
    if (mismatches == 0 && expected_pdus.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    calm_count++;
    if (calm_count >= 250) begin
      calm_count = 0;
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      m_tready <= 1'b0;
      stall_left = pick_gap_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [OFS_W-1:0] want,
                             input logic [OFS_W-1:0] got, inout int diffs);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch in pdu %0d: %s expected %h got %h", checked, name, want, got);
      diffs++;
    end
  endtask

  // outputs are stable at the falling edge; a transaction seen here completes at the next rise
  always @(negedge clk) begin
    result_t got, want;
    int      diffs;
    if (!rst && m_tvalid && m_tready) begin
      got.pdu_valid = m_tuser[0];
      got.pdu_kind = pdu_kind_t'(m_tuser[2:1]);
      got.pdu_offset = m_tdata[31:0];
      got.pdu_length = m_tdata[55:32];
      got.sequence_number = m_tdata[79:56];
      got.first_in_sequence = m_tdata[80];
      got.last_in_sequence = m_tdata[81];
      got.sequence_start_offset = m_tdata[113:82];
      got.sequence_bytes = m_tdata[137:114];
      got.sequence_pdus = m_tdata[161:138];
      got.transfer_done = m_tlast;
      if (expected_pdus.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected pdu transaction, offset %h length %h", got.pdu_offset,
                   got.pdu_length);
        mismatches++;
      end else begin
        want = expected_pdus.pop_front();
        diffs = 0;
        check_field("pdu_valid", OFS_W'(want.pdu_valid), OFS_W'(got.pdu_valid), diffs);
        check_field("pdu_offset", want.pdu_offset, got.pdu_offset, diffs);
        check_field("pdu_length", OFS_W'(want.pdu_length), OFS_W'(got.pdu_length), diffs);
        check_field("pdu_kind", OFS_W'(want.pdu_kind), OFS_W'(got.pdu_kind), diffs);
        check_field("sequence_number", OFS_W'(want.sequence_number),
                    OFS_W'(got.sequence_number), diffs);
        check_field("first_in_sequence", OFS_W'(want.first_in_sequence),
                    OFS_W'(got.first_in_sequence), diffs);
        check_field("last_in_sequence", OFS_W'(want.last_in_sequence),
                    OFS_W'(got.last_in_sequence), diffs);
        check_field("sequence_start_offset", want.sequence_start_offset,
                    got.sequence_start_offset, diffs);
        check_field("sequence_bytes", OFS_W'(want.sequence_bytes),
                    OFS_W'(got.sequence_bytes), diffs);
        check_field("sequence_pdus", OFS_W'(want.sequence_pdus),
                    OFS_W'(got.sequence_pdus), diffs);
        check_field("transfer_done", OFS_W'(want.transfer_done),
                    OFS_W'(got.transfer_done), diffs);
        if (diffs != 0) mismatches++;
        checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_run, expected_pdus.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
